FILE: rtl/bba_pkg.sv
// Shared types, constants and codes for the buddy block allocator.
`default_nettype none
package bba_pkg;

   localparam int MAX_ORDER_DEFAULT = 10;
   localparam int SHIFT_LIMIT       = 16;
   localparam int RESET_SHIFT       = 8;
   localparam int RESET_MAX_ORDER   = 10;
   localparam int BYTE_W            = 26;
   localparam int OFF_W             = 10;
   localparam int ORD_W             = 4;
   localparam int SIZE_W            = 32;
   localparam int SHIFT_W           = 5;
   localparam int CSR_DATA_W        = 5;

   localparam logic CSR_MIN_SHIFT = 1'b0;
   localparam logic CSR_MAX_ORDER = 1'b1;

   typedef enum logic [1:0] {
      ACT_ALLOC      = 2'd0,
      ACT_RELEASE    = 2'd1,
      ACT_POOL_RESET = 2'd2
   } action_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_SEED, S_IDLE, S_AMOD, S_UNITS, S_ORD, S_SRD, S_SCHK,
      S_SPLIT, S_BMOD, S_BFIX, S_RRD, S_RCHK, S_RSET, S_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_DIV_STEP, OP_UNITS, OP_ORD_INC, OP_SEARCH_INIT,
      OP_SREAD, OP_SFOUND, OP_SNEXT, OP_SPLIT, OP_BMOD_START, OP_BFIX,
      OP_RREAD, OP_RMERGE, OP_RSET, OP_CLEAR, OP_SEED, OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      action_type in_action;
      logic       in_align_nz;
      logic       in_rel_ok;
      logic       cfg_write;
      logic       align_nz;
      logic       div_done;
      logic       ord_gt_max;
      logic       ord_fits;
      logic       k_gt_max;
      logic       rd_bit;
      logic       idx_last;
      logic       j_gt_ord;
      logic       rord_lt_max;
      logic       clr_last;
      logic       slot_free;
   } status_type;

endpackage
`default_nettype wire

FILE: rtl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bba_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

FILE: rtl/bba_ctrl.sv
// Controller state machine sequencing allocate, release and pool clearing.
`default_nettype none
module bba_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire bba_pkg::status_type sts,
   output bba_pkg::cmd_type         cmd
);

   bba_pkg::state_type state_ff, state_in;
   logic               pend_ff, pend_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bba_pkg::S_CLEAR;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   assign req_tready = (state_ff == bba_pkg::S_IDLE);

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      cmd.op   = bba_pkg::OP_NONE;
      unique case (state_ff)
         bba_pkg::S_CLEAR: begin
            cmd.op = bba_pkg::OP_CLEAR;
            if (sts.clr_last) state_in = bba_pkg::S_SEED;
         end
         bba_pkg::S_SEED: begin
            cmd.op   = bba_pkg::OP_SEED;
            state_in = pend_ff ? bba_pkg::S_DONE : bba_pkg::S_IDLE;
            pend_in  = 1'b0;
         end
         bba_pkg::S_IDLE: begin
            if (req_tvalid) begin
               cmd.op = bba_pkg::OP_ACCEPT;
               unique case (sts.in_action)
                  bba_pkg::ACT_ALLOC:
                     state_in = sts.in_align_nz ? bba_pkg::S_AMOD : bba_pkg::S_UNITS;
                  bba_pkg::ACT_RELEASE:
                     state_in = sts.in_rel_ok ? bba_pkg::S_RRD : bba_pkg::S_DONE;
                  bba_pkg::ACT_POOL_RESET: begin
                     state_in = bba_pkg::S_CLEAR;
                     pend_in  = 1'b1;
                  end
                  default: state_in = bba_pkg::S_DONE;
               endcase
            end
         end
         bba_pkg::S_AMOD: begin
            if (sts.div_done) state_in = bba_pkg::S_UNITS;
            else cmd.op = bba_pkg::OP_DIV_STEP;
         end
         bba_pkg::S_UNITS: begin
            cmd.op   = bba_pkg::OP_UNITS;
            state_in = bba_pkg::S_ORD;
         end
         bba_pkg::S_ORD: begin
            priority if (sts.ord_gt_max) begin
               state_in = bba_pkg::S_DONE;
            end else if (sts.ord_fits) begin
               cmd.op   = bba_pkg::OP_SEARCH_INIT;
               state_in = bba_pkg::S_SRD;
            end else begin
               cmd.op = bba_pkg::OP_ORD_INC;
            end
         end
         bba_pkg::S_SRD: begin
            if (sts.k_gt_max) begin
               state_in = bba_pkg::S_DONE;
            end else begin
               cmd.op   = bba_pkg::OP_SREAD;
               state_in = bba_pkg::S_SCHK;
            end
         end
         bba_pkg::S_SCHK: begin
            if (sts.rd_bit) begin
               cmd.op   = bba_pkg::OP_SFOUND;
               state_in = bba_pkg::S_SPLIT;
            end else begin
               cmd.op   = bba_pkg::OP_SNEXT;
               state_in = bba_pkg::S_SRD;
            end
         end
         bba_pkg::S_SPLIT: begin
            priority if (sts.j_gt_ord) begin
               cmd.op = bba_pkg::OP_SPLIT;
            end else if (sts.align_nz) begin
               cmd.op   = bba_pkg::OP_BMOD_START;
               state_in = bba_pkg::S_BMOD;
            end else begin
               state_in = bba_pkg::S_BFIX;
            end
         end
         bba_pkg::S_BMOD: begin
            if (sts.div_done) state_in = bba_pkg::S_BFIX;
            else cmd.op = bba_pkg::OP_DIV_STEP;
         end
         bba_pkg::S_BFIX: begin
            cmd.op   = bba_pkg::OP_BFIX;
            state_in = bba_pkg::S_DONE;
         end
         bba_pkg::S_RRD: begin
            if (sts.rord_lt_max) begin
               cmd.op   = bba_pkg::OP_RREAD;
               state_in = bba_pkg::S_RCHK;
            end else begin
               state_in = bba_pkg::S_RSET;
            end
         end
         bba_pkg::S_RCHK: begin
            if (sts.rd_bit) begin
               cmd.op   = bba_pkg::OP_RMERGE;
               state_in = bba_pkg::S_RRD;
            end else begin
               state_in = bba_pkg::S_RSET;
            end
         end
         bba_pkg::S_RSET: begin
            cmd.op   = bba_pkg::OP_RSET;
            state_in = bba_pkg::S_DONE;
         end
         bba_pkg::S_DONE: begin
            if (sts.slot_free) begin
               cmd.op   = bba_pkg::OP_OUT;
               state_in = bba_pkg::S_IDLE;
            end
         end
         default: state_in = bba_pkg::S_CLEAR;
      endcase
      // A register write restarts the clearing pass and answers nothing.
      if (sts.cfg_write) begin
         state_in = bba_pkg::S_CLEAR;
         pend_in  = 1'b0;
         cmd.op   = bba_pkg::OP_NONE;
      end
   end

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item accepted while busy");

   a_seed_after_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bba_pkg::S_CLEAR && sts.clr_last && !sts.cfg_write)
      |=> state_ff == bba_pkg::S_SEED)
      else $error("clearing pass did not end in seeding");

   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      sts.cfg_write |=> state_ff == bba_pkg::S_CLEAR)
      else $error("register write did not start clearing pass");

endmodule
`default_nettype wire

FILE: rtl/bba_dp.sv
// Datapath: request registers, remainder unit, free-map addressing and result register.
`default_nettype none
module bba_dp #(
   parameter int MAX_ORDER = bba_pkg::MAX_ORDER_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire bba_pkg::cmd_type                  cmd,
   output bba_pkg::status_type                    sts,
   input  wire logic [1:0]                        in_action,
   input  wire logic [bba_pkg::SIZE_W-1:0]        in_size,
   input  wire logic [bba_pkg::SIZE_W-1:0]        in_align,
   input  wire logic [bba_pkg::OFF_W-1:0]         in_off,
   input  wire logic [bba_pkg::ORD_W-1:0]         in_order,
   input  wire logic                              csr_we,
   input  wire logic                              csr_index,
   input  wire logic [bba_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                                   ram_we,
   output logic [MAX_ORDER:0]                     ram_waddr,
   output logic                                   ram_wdata,
   output logic [MAX_ORDER:0]                     ram_raddr,
   input  wire logic                              ram_rdata,
   input  wire logic                              rsp_tready,
   output logic                                   rsp_valid,
   output logic                                   rsp_ok,
   output logic [bba_pkg::BYTE_W-1:0]             rsp_byte_offset,
   output logic [bba_pkg::OFF_W-1:0]              rsp_granted_offset,
   output logic [bba_pkg::ORD_W-1:0]              rsp_granted_order
);

   localparam int AW  = MAX_ORDER + 1;
   localparam int CW  = AW + 1;
   localparam int DW  = MAX_ORDER + bba_pkg::SHIFT_LIMIT;
   localparam int DCW = $clog2(DW + 1);
   localparam int UW  = 34;
   localparam logic [bba_pkg::ORD_W-1:0] MAXO_RST =
      (bba_pkg::RESET_MAX_ORDER > MAX_ORDER) ? bba_pkg::ORD_W'(MAX_ORDER)
                                             : bba_pkg::ORD_W'(bba_pkg::RESET_MAX_ORDER);

   function automatic logic [AW-1:0] node_of(input logic [4:0] order,
                                             input logic [MAX_ORDER-1:0] off);
      logic [AW-1:0] base;
      base = AW'(1) << (5'(MAX_ORDER) - order);
      return base + AW'(off >> order);
   endfunction

   logic [4:0]                shift_ff;
   logic [bba_pkg::ORD_W-1:0] maxo_ff;
   logic [bba_pkg::SIZE_W-1:0] size_ff, align_ff;
   logic [31:0]               rem_ff;
   logic [DW-1:0]             dvd_ff;
   logic [DCW-1:0]            cnt_ff;
   logic [UW-1:0]             units_ff;
   logic [4:0]                ord_ff, k_ff, j_ff, rord_ff;
   logic [MAX_ORDER-1:0]      idx_ff, off_ff, roff_ff;
   logic [CW-1:0]             clr_ff;
   logic                      res_ok_ff;
   logic [bba_pkg::BYTE_W-1:0] res_boff_ff;
   logic [bba_pkg::OFF_W-1:0] res_goff_ff;
   logic [bba_pkg::ORD_W-1:0] res_gord_ff;
   logic                      rsp_valid_ff, rsp_ok_ff;
   logic [bba_pkg::BYTE_W-1:0] rsp_boff_ff;
   logic [bba_pkg::OFF_W-1:0] rsp_goff_ff;
   logic [bba_pkg::ORD_W-1:0] rsp_gord_ff;

   logic [4:0]           maxo5;
   logic [32:0]          div_tmp;
   logic [31:0]          div_rem;
   logic [32:0]          need;
   logic [UW-1:0]        units_calc;
   logic [16:0]          rmask, rmasked;
   logic [MAX_ORDER-1:0] bud, sfound_off, split_off;
   logic [DW-1:0]        boff;
   logic [bba_pkg::BYTE_W-1:0] boff_adj;
   logic [4:0]           csr_sat;

   assign maxo5   = {1'b0, maxo_ff};
   assign div_tmp = {rem_ff, dvd_ff[DW-1]};
   assign div_rem = (div_tmp >= {1'b0, align_ff}) ? 32'(div_tmp - {1'b0, align_ff})
                                                  : div_tmp[31:0];
   assign need    = {1'b0, size_ff} + ((rem_ff != 32'd0) ? {1'b0, align_ff} : 33'd0);
   assign units_calc = (UW'(need) + (UW'(1) << shift_ff) - UW'(1)) >> shift_ff;
   assign rmask   = (17'(1) << in_order) - 17'(1);
   assign rmasked = 17'(in_off) & ~rmask;
   assign bud     = roff_ff ^ (MAX_ORDER'(1) << rord_ff);
   assign sfound_off = idx_ff << k_ff;
   assign split_off  = off_ff + (MAX_ORDER'(1) << (j_ff - 5'd1));
   assign boff     = DW'(off_ff) << shift_ff;
   assign boff_adj = (align_ff != 32'd0 && rem_ff != 32'd0)
      ? bba_pkg::BYTE_W'(boff) + align_ff[bba_pkg::BYTE_W-1:0]
        - rem_ff[bba_pkg::BYTE_W-1:0]
      : bba_pkg::BYTE_W'(boff);

   always_comb begin
      if (csr_index == bba_pkg::CSR_MIN_SHIFT) begin
         csr_sat = (csr_wdata > 5'(bba_pkg::SHIFT_LIMIT)) ? 5'(bba_pkg::SHIFT_LIMIT)
                                                          : csr_wdata;
      end else begin
         csr_sat = ({1'b0, csr_wdata[3:0]} > 5'(MAX_ORDER)) ? 5'(MAX_ORDER)
                                                            : {1'b0, csr_wdata[3:0]};
      end
   end

   always_comb begin
      sts.in_action   = bba_pkg::action_type'(in_action);
      sts.in_align_nz = (in_align != 32'd0);
      sts.in_rel_ok   = ({1'b0, in_order} <= maxo5) &&
                        (17'(in_off) < (17'(1) << maxo_ff));
      sts.cfg_write   = csr_we;
      sts.align_nz    = (align_ff != 32'd0);
      sts.div_done    = (cnt_ff == DCW'(0));
      sts.ord_gt_max  = (ord_ff > maxo5);
      sts.ord_fits    = ((35'(1) << ord_ff) >= 35'(units_ff));
      sts.k_gt_max    = (k_ff > maxo5);
      sts.rd_bit      = ram_rdata;
      sts.idx_last    = ((AW'(idx_ff) + AW'(1)) == (AW'(1) << (maxo5 - k_ff)));
      sts.j_gt_ord    = (j_ff > ord_ff);
      sts.rord_lt_max = (rord_ff < maxo5);
      sts.clr_last    = (clr_ff == CW'((1 << AW) - 1));
      sts.slot_free   = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_wdata = 1'b0;
      ram_waddr = clr_ff[AW-1:0];
      ram_raddr = node_of(rord_ff, bud);
      unique case (cmd.op)
         bba_pkg::OP_CLEAR:  ram_we = 1'b1;
         bba_pkg::OP_SEED: begin
            ram_we    = 1'b1;
            ram_wdata = 1'b1;
            ram_waddr = node_of(maxo5, '0);
         end
         bba_pkg::OP_SREAD:  ram_raddr = node_of(k_ff, sfound_off);
         bba_pkg::OP_SFOUND: begin
            ram_we    = 1'b1;
            ram_waddr = node_of(k_ff, sfound_off);
         end
         bba_pkg::OP_SPLIT: begin
            ram_we    = 1'b1;
            ram_wdata = 1'b1;
            ram_waddr = node_of(j_ff - 5'd1, split_off);
         end
         bba_pkg::OP_RMERGE: begin
            ram_we    = 1'b1;
            ram_waddr = node_of(rord_ff, bud);
         end
         bba_pkg::OP_RSET: begin
            ram_we    = 1'b1;
            ram_wdata = 1'b1;
            ram_waddr = node_of(rord_ff, roff_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= 5'(bba_pkg::RESET_SHIFT);
         maxo_ff      <= MAXO_RST;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (csr_we) begin
            if (csr_index == bba_pkg::CSR_MIN_SHIFT) shift_ff <= csr_sat;
            else maxo_ff <= csr_sat[3:0];
            clr_ff <= '0;
         end
         if (rsp_tready && cmd.op != bba_pkg::OP_OUT) rsp_valid_ff <= 1'b0;
         unique case (cmd.op)
            bba_pkg::OP_ACCEPT: begin
               size_ff     <= in_size;
               align_ff    <= in_align;
               rem_ff      <= '0;
               dvd_ff      <= DW'(1) << shift_ff;
               cnt_ff      <= DCW'(DW);
               ord_ff      <= '0;
               roff_ff     <= MAX_ORDER'(rmasked);
               rord_ff     <= {1'b0, in_order};
               clr_ff      <= '0;
               res_ok_ff   <= 1'b0;
               res_boff_ff <= '0;
               res_goff_ff <= '0;
               res_gord_ff <= '0;
            end
            bba_pkg::OP_DIV_STEP: begin
               rem_ff <= div_rem;
               dvd_ff <= dvd_ff << 1;
               cnt_ff <= cnt_ff - DCW'(1);
            end
            bba_pkg::OP_UNITS:  units_ff <= units_calc;
            bba_pkg::OP_ORD_INC: ord_ff <= ord_ff + 5'd1;
            bba_pkg::OP_SEARCH_INIT: begin
               k_ff   <= ord_ff;
               idx_ff <= '0;
            end
            bba_pkg::OP_SNEXT: begin
               if (sts.idx_last) begin
                  k_ff   <= k_ff + 5'd1;
                  idx_ff <= '0;
               end else begin
                  idx_ff <= idx_ff + MAX_ORDER'(1);
               end
            end
            bba_pkg::OP_SFOUND: begin
               off_ff <= sfound_off;
               j_ff   <= k_ff;
            end
            bba_pkg::OP_SPLIT: j_ff <= j_ff - 5'd1;
            bba_pkg::OP_BMOD_START: begin
               rem_ff <= '0;
               dvd_ff <= boff;
               cnt_ff <= DCW'(DW);
            end
            bba_pkg::OP_BFIX: begin
               res_ok_ff   <= 1'b1;
               res_boff_ff <= boff_adj;
               res_goff_ff <= bba_pkg::OFF_W'(off_ff);
               res_gord_ff <= bba_pkg::ORD_W'(ord_ff);
            end
            bba_pkg::OP_RMERGE: begin
               roff_ff <= roff_ff & bud;
               rord_ff <= rord_ff + 5'd1;
            end
            bba_pkg::OP_RSET: res_ok_ff <= 1'b1;
            bba_pkg::OP_CLEAR: if (!csr_we) clr_ff <= clr_ff + CW'(1);
            bba_pkg::OP_SEED: res_ok_ff <= 1'b1;
            bba_pkg::OP_OUT: begin
               rsp_valid_ff <= 1'b1;
               rsp_ok_ff    <= res_ok_ff;
               rsp_boff_ff  <= res_boff_ff;
               rsp_goff_ff  <= res_goff_ff;
               rsp_gord_ff  <= res_gord_ff;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_byte_offset    = rsp_boff_ff;
   assign rsp_granted_offset = rsp_goff_ff;
   assign rsp_granted_order  = rsp_gord_ff;

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_boff_ff == '0 && rsp_goff_ff == '0
                                        && rsp_gord_ff == '0))
      else $error("failed result carries nonzero fields");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == bba_pkg::OP_SREAD || cmd.op == bba_pkg::OP_RREAD) |-> !ram_we)
      else $error("free map written during a probe read");

   a_grant_range: assert property (@(posedge clock) disable iff (reset)
      cmd.op == bba_pkg::OP_BFIX |-> ord_ff <= maxo5)
      else $error("granted order above pool order");

endmodule
`default_nettype wire

FILE: rtl/buddy_block_allocator_core.sv
// Buddy block allocator: top level joining controller, datapath and free-map RAM.
//
// Requests arrive on the req_ stream; one result per request leaves on rsp_.
// req_tuser carries the action (allocate, release, reset pool); req_tdata
// carries size, alignment, block offset and block order. The result gives
// ok, the aligned byte offset, the granted block offset and its order.
// One request is worked on at a time; a new one is taken while the last
// result still waits in the output register.
// Allocate: with nonzero alignment the bit-serial remainder unit
// (DW = MAX_ORDER + 16) makes one pass before the order is found and one
// after the split, none with zero alignment; the order is found one step at
// a time, free-map entries are probed in the lowest-free search and the block
// is split one level per step. Release: merges with free buddies level by level.
// Pool reset: a clearing pass over all 2^(MAX_ORDER+1) free-map RAM entries.
// After reset and after every csr_ write the same clearing pass runs and no
// request is taken; it gives no result. A stalled rsp_ leaves the result in
// the output register and the block holds before its next result.
`default_nettype none
module buddy_block_allocator_core #(
   parameter int MAX_ORDER = bba_pkg::MAX_ORDER_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [31:0] size_bytes, [63:32] alignment, [73:64] block_offset, [77:74] block_order
   input  wire logic [79:0] req_tdata,
   // [1:0] action
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] ok, [26:1] byte_offset, [36:27] granted_offset, [40:37] granted_order
   output logic [47:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [4:0]  csr_wdata
);

   bba_pkg::cmd_type    cmd;
   bba_pkg::status_type sts;
   logic                ram_we, ram_wdata, ram_rdata;
   logic [MAX_ORDER:0]  ram_waddr, ram_raddr;
   logic                ok;
   logic [25:0]         byte_offset;
   logic [9:0]          granted_offset;
   logic [3:0]          granted_order;

   bba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bba_dp #(.MAX_ORDER(MAX_ORDER)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .in_action          (req_tuser),
      .in_size            (req_tdata[31:0]),
      .in_align           (req_tdata[63:32]),
      .in_off             (req_tdata[73:64]),
      .in_order           (req_tdata[77:74]),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .ram_we             (ram_we),
      .ram_waddr          (ram_waddr),
      .ram_wdata          (ram_wdata),
      .ram_raddr          (ram_raddr),
      .ram_rdata          (ram_rdata),
      .rsp_tready         (rsp_tready),
      .rsp_valid          (rsp_tvalid),
      .rsp_ok             (ok),
      .rsp_byte_offset    (byte_offset),
      .rsp_granted_offset (granted_offset),
      .rsp_granted_order  (granted_order)
   );

   bba_ram #(.WIDTH(1), .DEPTH(1 << (MAX_ORDER + 1))) u_free_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_tdata = {7'd0, granted_order, granted_offset, byte_offset, ok};

endmodule
`default_nettype wire
